FILE: rtl/core/biquad_four_form_filter_top_macros.svh
// Assertion macros of the biquad core RTL.
`ifndef BIQUAD_FOUR_FORM_FILTER_TOP_MACROS_SVH
`define BIQUAD_FOUR_FORM_FILTER_TOP_MACROS_SVH

// Consequent checked in the same cycle as the antecedent.
`define BQF_ASSERT_NOW(label, ck, rn, ante, cons, msg) \
	label: assert property (@(posedge ck) disable iff (!rn) (ante) |-> (cons)) \
		else $error(msg);

// Consequent checked in the cycle after the antecedent.
`define BQF_ASSERT_NEXT(label, ck, rn, ante, cons, msg) \
	label: assert property (@(posedge ck) disable iff (!rn) (ante) |=> (cons)) \
		else $error(msg);

`endif

FILE: rtl/core/bqf_pkg.sv
// Shared types, constants, microcode program and saturation helpers of the biquad core.
package bqf_pkg;

	localparam int SAMPLE_WIDTH = 24;
	localparam int COEF_WIDTH   = 24;
	localparam int STATE_WIDTH  = 32;
	localparam int COEF_FRAC    = COEF_WIDTH - 4;
	localparam int MUL_W        = COEF_WIDTH + STATE_WIDTH;
	localparam int PROD_W       = MUL_W - COEF_FRAC;
	localparam int ACC_W        = PROD_W + 4;
	localparam int FORM_W       = 2;
	localparam int CFG_W        = COEF_WIDTH;
	localparam int CFG_IDX_W    = 3;
	localparam int PROG_LEN     = 42;
	localparam int PC_W         = $clog2(PROG_LEN);

	typedef logic signed [COEF_WIDTH-1:0]   coef_t;
	typedef logic signed [STATE_WIDTH-1:0]  state_t;
	typedef logic signed [SAMPLE_WIDTH-1:0] sample_t;
	typedef logic signed [ACC_W-1:0]        acc_t;

	localparam coef_t COEF_ONE = coef_t'(64'sd1 <<< COEF_FRAC);
	localparam logic [MUL_W-1:0] MUL_HALF = MUL_W'(1) << (COEF_FRAC - 1);
	localparam acc_t ST_HI  = acc_t'((64'sd1 <<< (STATE_WIDTH - 1)) - 64'sd1);
	localparam acc_t ST_LO  = ~ST_HI;
	localparam acc_t SMP_HI = acc_t'((64'sd1 <<< (SAMPLE_WIDTH - 1)) - 64'sd1);
	localparam acc_t SMP_LO = ~SMP_HI;

	typedef enum logic [FORM_W-1:0] {
		FORM_DIRECT, FORM_CANON, FORM_TDIRECT, FORM_TCANON
	} form_t;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_FORM, REG_A0, REG_A1, REG_A2, REG_B1, REG_B2, REG_WET, REG_DRY
	} cfg_reg_t;

	typedef struct packed {
		form_t form;
		coef_t a0;
		coef_t a1;
		coef_t a2;
		coef_t b1;
		coef_t b2;
		coef_t wet;
		coef_t dry;
	} cfg_t;

	// Fields of one control word.
	typedef enum logic [2:0] {C_A0, C_A1, C_A2, C_B1, C_B2, C_WET, C_DRY} coef_sel_t;
	typedef enum logic [2:0] {O_X, O_W, O_Y, O_FF1, O_FF2, O_FB1, O_FB2} opnd_sel_t;
	typedef enum logic {AB_ZERO, AB_ACC} acc_base_t;
	typedef enum logic [2:0] {R_ZERO, R_X, R_FF1, R_FF2, R_FB1, R_FB2} reg_sel_t;
	typedef enum logic [1:0] {P_NONE, P_ADD, P_SUB} prod_op_t;
	typedef enum logic [2:0] {D_NONE, D_W, D_Y, D_FF1, D_FF2, D_FB1, D_FB2, D_OUT} dest_t;
	typedef enum logic [1:0] {U_NONE, U_DIRECT, U_CANON} shift_t;
	typedef enum logic [1:0] {J_NEXT, J_FORM, J_END} jump_t;

	typedef struct packed {
		coef_sel_t mc;
		opnd_sel_t mo;
		acc_base_t ab;
		reg_sel_t  rs;
		prod_op_t  ap;
		dest_t     dst;
		shift_t    upd;
		jump_t     jmp;
	} uop_t;

	typedef struct packed {
		uop_t uop;
		logic x_ld;
		logic out_ld;
	} seq_ctl_t;

	localparam uop_t UOP_NOP = '{mc: C_A0, mo: O_X, ab: AB_ACC, rs: R_ZERO, ap: P_NONE,
		dst: D_NONE, upd: U_NONE, jmp: J_NEXT};

	localparam logic [PC_W-1:0] PC_DISPATCH = PC_W'(0);
	localparam logic [PC_W-1:0] PC_F0 = PC_W'(1);
	localparam logic [PC_W-1:0] PC_F1 = PC_W'(10);
	localparam logic [PC_W-1:0] PC_F2 = PC_W'(20);
	localparam logic [PC_W-1:0] PC_F3 = PC_W'(32);

	function automatic uop_t mk(input coef_sel_t mc, input opnd_sel_t mo, input acc_base_t ab,
		input reg_sel_t rs, input prod_op_t ap, input dest_t dst, input shift_t upd,
		input jump_t jmp);
		uop_t u;
		u = '{mc: mc, mo: mo, ab: ab, rs: rs, ap: ap, dst: dst, upd: upd, jmp: jmp};
		return u;
	endfunction

	function automatic logic [PC_W-1:0] entry_pc(input form_t f);
		logic [PC_W-1:0] e;
		case (f)
			FORM_DIRECT:  e = PC_F0;
			FORM_CANON:   e = PC_F1;
			FORM_TDIRECT: e = PC_F2;
			default:      e = PC_F3;
		endcase
		return e;
	endfunction

	// The product of a step is registered and is added by the following step.
	// A destination write takes the accumulator as it stood before the step.
	function automatic uop_t rom_word(input logic [PC_W-1:0] pc);
		uop_t u;
		case (pc)
			// Common entry: start a0*x, load x, branch on the form.
			PC_W'(0):  u = mk(C_A0,  O_X,   AB_ZERO, R_X,    P_NONE, D_NONE, U_NONE,   J_FORM);
			// Direct form I.
			PC_W'(1):  u = mk(C_A1,  O_FF1, AB_ZERO, R_ZERO, P_ADD,  D_NONE, U_NONE,   J_NEXT);
			PC_W'(2):  u = mk(C_A2,  O_FF2, AB_ACC,  R_ZERO, P_ADD,  D_NONE, U_NONE,   J_NEXT);
			PC_W'(3):  u = mk(C_B1,  O_FB1, AB_ACC,  R_ZERO, P_ADD,  D_NONE, U_NONE,   J_NEXT);
			PC_W'(4):  u = mk(C_B2,  O_FB2, AB_ACC,  R_ZERO, P_SUB,  D_NONE, U_NONE,   J_NEXT);
			PC_W'(5):  u = mk(C_DRY, O_X,   AB_ACC,  R_ZERO, P_SUB,  D_NONE, U_NONE,   J_NEXT);
			PC_W'(6):  u = mk(C_WET, O_Y,   AB_ZERO, R_ZERO, P_ADD,  D_Y,    U_DIRECT, J_NEXT);
			PC_W'(7):  u = mk(C_WET, O_Y,   AB_ACC,  R_ZERO, P_NONE, D_NONE, U_NONE,   J_NEXT);
			PC_W'(8):  u = mk(C_WET, O_Y,   AB_ACC,  R_ZERO, P_ADD,  D_NONE, U_NONE,   J_NEXT);
			PC_W'(9):  u = mk(C_WET, O_Y,   AB_ACC,  R_ZERO, P_NONE, D_OUT,  U_NONE,   J_END);
			// Canonical form.
			PC_W'(10): u = mk(C_B1,  O_FF1, AB_ACC,  R_ZERO, P_NONE, D_NONE, U_NONE,   J_NEXT);
			PC_W'(11): u = mk(C_B2,  O_FF2, AB_ACC,  R_ZERO, P_SUB,  D_NONE, U_NONE,   J_NEXT);
			PC_W'(12): u = mk(C_A1,  O_FF1, AB_ACC,  R_ZERO, P_SUB,  D_NONE, U_NONE,   J_NEXT);
			PC_W'(13): u = mk(C_A2,  O_FF2, AB_ZERO, R_ZERO, P_ADD,  D_W,    U_NONE,   J_NEXT);
			PC_W'(14): u = mk(C_A0,  O_W,   AB_ACC,  R_ZERO, P_ADD,  D_NONE, U_NONE,   J_NEXT);
			PC_W'(15): u = mk(C_DRY, O_X,   AB_ACC,  R_ZERO, P_ADD,  D_NONE, U_NONE,   J_NEXT);
			PC_W'(16): u = mk(C_WET, O_Y,   AB_ZERO, R_ZERO, P_ADD,  D_Y,    U_CANON,  J_NEXT);
			PC_W'(17): u = mk(C_WET, O_Y,   AB_ACC,  R_ZERO, P_NONE, D_NONE, U_NONE,   J_NEXT);
			PC_W'(18): u = mk(C_WET, O_Y,   AB_ACC,  R_ZERO, P_ADD,  D_NONE, U_NONE,   J_NEXT);
			PC_W'(19): u = mk(C_WET, O_Y,   AB_ACC,  R_ZERO, P_NONE, D_OUT,  U_NONE,   J_END);
			// Transposed direct form.
			PC_W'(20): u = mk(C_A0,  O_W,   AB_ACC,  R_FB1,  P_NONE, D_NONE, U_NONE,   J_NEXT);
			PC_W'(21): u = mk(C_A0,  O_W,   AB_ACC,  R_ZERO, P_NONE, D_W,    U_NONE,   J_NEXT);
			PC_W'(22): u = mk(C_A0,  O_W,   AB_ACC,  R_ZERO, P_NONE, D_NONE, U_NONE,   J_NEXT);
			PC_W'(23): u = mk(C_B1,  O_W,   AB_ZERO, R_FF1,  P_ADD,  D_NONE, U_NONE,   J_NEXT);
			PC_W'(24): u = mk(C_B2,  O_W,   AB_ZERO, R_FB2,  P_SUB,  D_Y,    U_NONE,   J_NEXT);
			PC_W'(25): u = mk(C_A1,  O_W,   AB_ZERO, R_ZERO, P_SUB,  D_FB1,  U_NONE,   J_NEXT);
			PC_W'(26): u = mk(C_A2,  O_W,   AB_ZERO, R_FF2,  P_ADD,  D_FB2,  U_NONE,   J_NEXT);
			PC_W'(27): u = mk(C_DRY, O_X,   AB_ZERO, R_ZERO, P_ADD,  D_FF1,  U_NONE,   J_NEXT);
			PC_W'(28): u = mk(C_WET, O_Y,   AB_ZERO, R_ZERO, P_ADD,  D_FF2,  U_NONE,   J_NEXT);
			PC_W'(29): u = mk(C_WET, O_Y,   AB_ACC,  R_ZERO, P_NONE, D_NONE, U_NONE,   J_NEXT);
			PC_W'(30): u = mk(C_WET, O_Y,   AB_ACC,  R_ZERO, P_ADD,  D_NONE, U_NONE,   J_NEXT);
			PC_W'(31): u = mk(C_WET, O_Y,   AB_ACC,  R_ZERO, P_NONE, D_OUT,  U_NONE,   J_END);
			// Transposed canonical form.
			PC_W'(32): u = mk(C_A1,  O_X,   AB_ZERO, R_FF1,  P_ADD,  D_NONE, U_NONE,   J_NEXT);
			PC_W'(33): u = mk(C_B1,  O_Y,   AB_ZERO, R_FF2,  P_ADD,  D_Y,    U_NONE,   J_NEXT);
			PC_W'(34): u = mk(C_B1,  O_Y,   AB_ACC,  R_ZERO, P_NONE, D_NONE, U_NONE,   J_NEXT);
			PC_W'(35): u = mk(C_A2,  O_X,   AB_ACC,  R_ZERO, P_SUB,  D_NONE, U_NONE,   J_NEXT);
			PC_W'(36): u = mk(C_B2,  O_Y,   AB_ZERO, R_ZERO, P_ADD,  D_FF1,  U_NONE,   J_NEXT);
			PC_W'(37): u = mk(C_DRY, O_X,   AB_ACC,  R_ZERO, P_SUB,  D_NONE, U_NONE,   J_NEXT);
			PC_W'(38): u = mk(C_WET, O_Y,   AB_ZERO, R_ZERO, P_ADD,  D_FF2,  U_NONE,   J_NEXT);
			PC_W'(39): u = mk(C_WET, O_Y,   AB_ACC,  R_ZERO, P_NONE, D_NONE, U_NONE,   J_NEXT);
			PC_W'(40): u = mk(C_WET, O_Y,   AB_ACC,  R_ZERO, P_ADD,  D_NONE, U_NONE,   J_NEXT);
			PC_W'(41): u = mk(C_WET, O_Y,   AB_ACC,  R_ZERO, P_NONE, D_OUT,  U_NONE,   J_END);
			default:   u = mk(C_A0,  O_X,   AB_ACC,  R_ZERO, P_NONE, D_NONE, U_NONE,   J_END);
		endcase
		return u;
	endfunction

	function automatic state_t sat_state(input acc_t v);
		state_t r;
		if (v > ST_HI) begin
			r = state_t'(ST_HI);
		end else if (v < ST_LO) begin
			r = state_t'(ST_LO);
		end else begin
			r = v[STATE_WIDTH-1:0];
		end
		return r;
	endfunction

	function automatic sample_t sat_sample(input acc_t v);
		sample_t r;
		if (v > SMP_HI) begin
			r = sample_t'(SMP_HI);
		end else if (v < SMP_LO) begin
			r = sample_t'(SMP_LO);
		end else begin
			r = v[SAMPLE_WIDTH-1:0];
		end
		return r;
	endfunction

endpackage

FILE: rtl/core/biquad_four_form_filter_top.sv
// The program runs a separate step sequence for each of the direct, canonical, transposed
// direct and transposed canonical forms.
// A new input word is taken only once the previous word has retired; each product of the program passes
// through the single shared multiplier, one per microcode step.
// Reset clears the sequencer, output valid and the four delay registers, and loads the
// register defaults (direct form, a0 and wet gain at 1.0, all others zero).
module biquad_four_form_filter_top (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          cfg_we,
	input  logic [bqf_pkg::CFG_IDX_W-1:0] cfg_index,
	input  logic [bqf_pkg::CFG_W-1:0]     cfg_data,
	input  logic                          in_valid,
	output logic                          in_stall,
	input  logic signed [bqf_pkg::SAMPLE_WIDTH-1:0] sample_in,
	output logic                          out_valid,
	input  logic                          out_stall,
	output logic signed [bqf_pkg::SAMPLE_WIDTH-1:0] sample_out
);

	bqf_pkg::cfg_t     cfg;
	bqf_pkg::seq_ctl_t ctl;

	bqf_cfg u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.cfg       (cfg)
	);

	bqf_useq u_useq (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.form      (cfg.form),
		.ctl       (ctl)
	);

	bqf_dpath u_dpath (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg        (cfg),
		.ctl        (ctl),
		.sample_in  (sample_in),
		.sample_out (sample_out)
	);

endmodule

FILE: rtl/core/bqf_cfg.sv
// Configuration register bank of the biquad core: form select, coefficients and mix gains.
module bqf_cfg (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          cfg_we,
	input  logic [bqf_pkg::CFG_IDX_W-1:0] cfg_index,
	input  logic [bqf_pkg::CFG_W-1:0]     cfg_data,
	output bqf_pkg::cfg_t                 cfg
);

	bqf_pkg::cfg_t cfg_q;
	bqf_pkg::coef_t wr_coef;

	assign wr_coef = cfg_data[bqf_pkg::COEF_WIDTH-1:0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.form <= bqf_pkg::FORM_DIRECT;
			cfg_q.a0   <= bqf_pkg::COEF_ONE;
			cfg_q.a1   <= '0;
			cfg_q.a2   <= '0;
			cfg_q.b1   <= '0;
			cfg_q.b2   <= '0;
			cfg_q.wet  <= bqf_pkg::COEF_ONE;
			cfg_q.dry  <= '0;
		end else if (cfg_we) begin
			case (bqf_pkg::cfg_reg_t'(cfg_index))
				bqf_pkg::REG_FORM: cfg_q.form <= bqf_pkg::form_t'(cfg_data[bqf_pkg::FORM_W-1:0]);
				bqf_pkg::REG_A0:   cfg_q.a0   <= wr_coef;
				bqf_pkg::REG_A1:   cfg_q.a1   <= wr_coef;
				bqf_pkg::REG_A2:   cfg_q.a2   <= wr_coef;
				bqf_pkg::REG_B1:   cfg_q.b1   <= wr_coef;
				bqf_pkg::REG_B2:   cfg_q.b2   <= wr_coef;
				bqf_pkg::REG_WET:  cfg_q.wet  <= wr_coef;
				bqf_pkg::REG_DRY:  cfg_q.dry  <= wr_coef;
				default: begin
				end
			endcase
		end
	end

	assign cfg = cfg_q;

endmodule

FILE: rtl/core/bqf_useq.sv
// Microcode sequencer of the biquad core: step counter, program table and word handshake.
`include "biquad_four_form_filter_top_macros.svh"

module bqf_useq (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_stall,
	output logic              out_valid,
	input  logic              out_stall,
	input  bqf_pkg::form_t    form,
	output bqf_pkg::seq_ctl_t ctl
);

	logic                      busy_q;
	logic                      out_valid_q;
	logic [bqf_pkg::PC_W-1:0]  pc_q;
	logic [bqf_pkg::PC_W-1:0]  pc_d;
	bqf_pkg::uop_t             cur;
	logic                      accept;
	logic                      at_end;
	logic                      out_free;
	logic                      retire;

	assign in_stall  = busy_q;
	assign out_valid = out_valid_q;
	assign accept    = in_valid && !busy_q;
	assign out_free  = !out_valid_q || !out_stall;

	always_comb begin
		cur = busy_q ? bqf_pkg::rom_word(pc_q) : bqf_pkg::UOP_NOP;
	end

	assign at_end = busy_q && (cur.jmp == bqf_pkg::J_END);
	// The last step waits there until the output register can take the word.
	assign retire = at_end && out_free;

	always_comb begin
		pc_d = pc_q;
		if (accept) begin
			pc_d = bqf_pkg::PC_DISPATCH;
		end else if (busy_q) begin
			case (cur.jmp)
				bqf_pkg::J_NEXT: pc_d = pc_q + bqf_pkg::PC_W'(1);
				bqf_pkg::J_FORM: pc_d = bqf_pkg::entry_pc(form);
				bqf_pkg::J_END:  pc_d = pc_q;
				default:         pc_d = pc_q;
			endcase
		end
	end

	always_comb begin
		ctl.uop    = cur;
		ctl.x_ld   = accept;
		ctl.out_ld = retire && (cur.dst == bqf_pkg::D_OUT);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q      <= 1'b0;
			pc_q        <= bqf_pkg::PC_DISPATCH;
			out_valid_q <= 1'b0;
		end else begin
			pc_q <= pc_d;
			if (accept) begin
				busy_q <= 1'b1;
			end else if (retire) begin
				busy_q <= 1'b0;
			end
			if (retire) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	`BQF_ASSERT_NEXT(a_accept_starts, clk, arst_n, accept, busy_q && (pc_q == bqf_pkg::PC_DISPATCH), "accepted word did not start the program at dispatch")
	`BQF_ASSERT_NOW(a_pc_in_range, clk, arst_n, busy_q, pc_q < bqf_pkg::PC_W'(bqf_pkg::PROG_LEN), "step counter left the program")
	`BQF_ASSERT_NOW(a_branch_only_dispatch, clk, arst_n, busy_q && (pc_q != bqf_pkg::PC_DISPATCH), cur.jmp != bqf_pkg::J_FORM, "form branch outside the dispatch step")
	`BQF_ASSERT_NOW(a_done_gives_word, clk, arst_n, $fell(busy_q), out_valid_q, "finished word did not reach the output register")

endmodule

FILE: rtl/core/bqf_dpath.sv
// Datapath of the biquad core: shared multiplier, accumulator, delay registers and output register.
module bqf_dpath (
	input  logic              clk,
	input  logic              arst_n,
	input  bqf_pkg::cfg_t     cfg,
	input  bqf_pkg::seq_ctl_t ctl,
	input  bqf_pkg::sample_t  sample_in,
	output bqf_pkg::sample_t  sample_out
);

	bqf_pkg::state_t x_q;
	bqf_pkg::state_t w_q;
	bqf_pkg::state_t y_q;
	bqf_pkg::state_t ff1_q;
	bqf_pkg::state_t ff2_q;
	bqf_pkg::state_t fb1_q;
	bqf_pkg::state_t fb2_q;
	bqf_pkg::acc_t   acc_q;
	bqf_pkg::sample_t out_q;

	logic signed [bqf_pkg::PROD_W-1:0] p_s1;
	logic signed [bqf_pkg::MUL_W-1:0]  mul_full;
	logic [bqf_pkg::MUL_W-1:0]         mul_rnd;

	bqf_pkg::coef_t  mc_v;
	bqf_pkg::state_t mo_v;
	bqf_pkg::state_t rs_v;
	bqf_pkg::acc_t   base_v;
	bqf_pkg::acc_t   term_v;
	bqf_pkg::acc_t   acc_d;
	bqf_pkg::state_t sat_v;

	always_comb begin
		case (ctl.uop.mc)
			bqf_pkg::C_A0:  mc_v = cfg.a0;
			bqf_pkg::C_A1:  mc_v = cfg.a1;
			bqf_pkg::C_A2:  mc_v = cfg.a2;
			bqf_pkg::C_B1:  mc_v = cfg.b1;
			bqf_pkg::C_B2:  mc_v = cfg.b2;
			bqf_pkg::C_WET: mc_v = cfg.wet;
			bqf_pkg::C_DRY: mc_v = cfg.dry;
			default:        mc_v = cfg.a0;
		endcase
	end

	always_comb begin
		case (ctl.uop.mo)
			bqf_pkg::O_X:   mo_v = x_q;
			bqf_pkg::O_W:   mo_v = w_q;
			bqf_pkg::O_Y:   mo_v = y_q;
			bqf_pkg::O_FF1: mo_v = ff1_q;
			bqf_pkg::O_FF2: mo_v = ff2_q;
			bqf_pkg::O_FB1: mo_v = fb1_q;
			bqf_pkg::O_FB2: mo_v = fb2_q;
			default:        mo_v = x_q;
		endcase
	end

	// Adding half an LSB before the arithmetic shift rounds the product to the value's format.
	assign mul_full = mc_v * mo_v;
	assign mul_rnd  = mul_full + bqf_pkg::MUL_HALF;

	always_ff @(posedge clk) begin
		p_s1 <= mul_rnd[bqf_pkg::MUL_W-1:bqf_pkg::COEF_FRAC];
	end

	always_comb begin
		case (ctl.uop.rs)
			bqf_pkg::R_ZERO: rs_v = '0;
			bqf_pkg::R_X:    rs_v = x_q;
			bqf_pkg::R_FF1:  rs_v = ff1_q;
			bqf_pkg::R_FF2:  rs_v = ff2_q;
			bqf_pkg::R_FB1:  rs_v = fb1_q;
			bqf_pkg::R_FB2:  rs_v = fb2_q;
			default:         rs_v = '0;
		endcase
	end

	always_comb begin
		base_v = (ctl.uop.ab == bqf_pkg::AB_ACC) ? acc_q : '0;
		case (ctl.uop.ap)
			bqf_pkg::P_ADD: term_v = bqf_pkg::acc_t'(p_s1);
			bqf_pkg::P_SUB: term_v = -bqf_pkg::acc_t'(p_s1);
			default:        term_v = '0;
		endcase
		acc_d = base_v + bqf_pkg::acc_t'(rs_v) + term_v;
		sat_v = bqf_pkg::sat_state(acc_q);
	end

	always_ff @(posedge clk) begin
		acc_q <= acc_d;
		if (ctl.x_ld) begin
			x_q <= bqf_pkg::state_t'(sample_in);
		end
		if (ctl.uop.dst == bqf_pkg::D_W) begin
			w_q <= sat_v;
		end
		if (ctl.uop.dst == bqf_pkg::D_Y) begin
			y_q <= sat_v;
		end
		if (ctl.out_ld) begin
			out_q <= bqf_pkg::sat_sample(acc_q);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ff1_q <= '0;
			ff2_q <= '0;
			fb1_q <= '0;
			fb2_q <= '0;
		end else begin
			case (ctl.uop.dst)
				bqf_pkg::D_FF1: ff1_q <= sat_v;
				bqf_pkg::D_FF2: ff2_q <= sat_v;
				bqf_pkg::D_FB1: fb1_q <= sat_v;
				bqf_pkg::D_FB2: fb2_q <= sat_v;
				default: begin
				end
			endcase
			// Direct form shifts both delay lines; canonical form shifts the w line only.
			case (ctl.uop.upd)
				bqf_pkg::U_DIRECT: begin
					ff2_q <= ff1_q;
					ff1_q <= x_q;
					fb2_q <= fb1_q;
					fb1_q <= sat_v;
				end
				bqf_pkg::U_CANON: begin
					ff2_q <= ff1_q;
					ff1_q <= w_q;
				end
				default: begin
				end
			endcase
		end
	end

	assign sample_out = out_q;

endmodule
